FILE: rtl/tone_keying_edge_timer_unit_macros.svh
// Assertion helpers used by the RTL queue
`ifndef TONE_KEYING_EDGE_TIMER_UNIT_MACROS_SVH
`define TONE_KEYING_EDGE_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored during rst
`define TKET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and ignored during rst
`define TKET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tket_pkg.sv
`timescale 1ns / 1ps

package tket_pkg;

  // Event codes on the result side
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_SILENCE_END = 3'd1;
  localparam logic [2:0] EV_TONE_END    = 3'd2;
  localparam logic [2:0] EV_FLUSH       = 3'd3;
  localparam logic [2:0] EV_MSG_END     = 3'd4;

  // Mode codes as reported on the result side
  localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CODE_TONE   = 2'd1;
  localparam logic [1:0] MODE_CODE_SILENT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LEVEL_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_SAMPLES = 2'd1;
  localparam logic [1:0] REG_LETTER_FLUSH_MS  = 2'd2;
  localparam logic [1:0] REG_MESSAGE_END_MS   = 2'd3;

  // Queue between the averaging front and the keying back end
  localparam int QUEUE_DEPTH = 4;

  // Receiver state, one-hot
  typedef enum logic [2:0] {
    RX_IDLE   = 3'b001,
    RX_TONE   = 3'b010,
    RX_SILENT = 3'b100
  } rx_mode_t;

  // Configuration register set
  typedef struct packed {
    logic [11:0] level_threshold;
    logic [7:0]  debounce_samples;
    logic [15:0] letter_flush_ms;
    logic [23:0] message_end_ms;
  } cfg_t;

  // One classified word handed from front to back
  typedef struct packed {
    logic [11:0] average;
    logic [31:0] time_ms;
    logic        decoder_done;
    logic        decoder_has_text;
  } q_item_t;

  function automatic logic [1:0] mode_code(rx_mode_t m);
    logic [1:0] code;
    code = MODE_CODE_IDLE;
    unique case (m)
      RX_IDLE:   code = MODE_CODE_IDLE;
      RX_TONE:   code = MODE_CODE_TONE;
      RX_SILENT: code = MODE_CODE_SILENT;
      default:   code = MODE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/tket_front.sv
`timescale 1ns / 1ps

module tket_front #(
  parameter int WINDOW_LEN = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [11:0]       sample,
  input  logic [31:0]       time_ms,
  input  logic              decoder_done,
  input  logic              decoder_has_text,
  input  logic              q_full,
  output logic              q_push,
  output tket_pkg::q_item_t q_item
);

  localparam int LEN_W   = $clog2(WINDOW_LEN);
  localparam int SUM_W   = 12 + LEN_W;
  localparam int SH      = SUM_W + LEN_W;
  localparam int RECIP_W = SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP = ((64'd1 << SH) + WINDOW_LEN - 1) / WINDOW_LEN;

  logic [11:0]       win [WINDOW_LEN];
  logic              primed;
  logic [SUM_W-1:0]  sum;
  logic              s1_valid;
  logic [31:0]       s1_time;
  logic              s1_done;
  logic              s1_has_text;
  logic              accept;
  logic [PROD_W-1:0] prod;

  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid && !q_full;

  // Shift the window; the first sample fills every tap
  always_ff @(posedge clk) begin
    if (accept && !decoder_done) begin
      if (!primed) begin
        for (int i = 0; i < WINDOW_LEN; i++) win[i] <= sample;
      end else begin
        win[0] <= sample;
        for (int i = 1; i < WINDOW_LEN; i++) win[i] <= win[i-1];
      end
    end
  end

  // Keep a running sum of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      sum    <= '0;
    end else if (accept && !decoder_done) begin
      primed <= 1'b1;
      if (!primed) begin
        sum <= SUM_W'(32'(sample) * WINDOW_LEN);
      end else begin
        sum <= sum - SUM_W'(win[WINDOW_LEN-1]) + SUM_W'(sample);
      end
    end
  end

  // Hold the accepted word until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time     <= time_ms;
      s1_done     <= decoder_done;
      s1_has_text <= decoder_has_text;
    end
  end

  // Floored mean by reciprocal multiply, exact over the whole sum range
  assign prod = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));

  always_comb begin
    q_item.average          = prod[SH +: 12];
    q_item.time_ms          = s1_time;
    q_item.decoder_done     = s1_done;
    q_item.decoder_has_text = s1_has_text;
  end

endmodule

FILE: rtl/tket_queue.sv
`timescale 1ns / 1ps

module tket_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tket_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output tket_pkg::q_item_t pop_item
);

  `include "tone_keying_edge_timer_unit_macros.svh"

  localparam int DEPTH = tket_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tket_pkg::q_item_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign pop_item = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `TKET_ASSERT_NOW(a_no_push_full, push, !full || pop, "push into full queue")
  `TKET_ASSERT_NOW(a_no_pop_empty, pop, nonempty, "pop from empty queue")
  `TKET_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not rise")

endmodule

FILE: rtl/tket_back.sv
`timescale 1ns / 1ps

module tket_back (
  input  logic              clk,
  input  logic              rst,
  input  tket_pkg::cfg_t    cfg,
  input  logic              q_nonempty,
  input  tket_pkg::q_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_res,
  output logic [31:0]       duration_ms,
  output logic [11:0]       average,
  output logic [1:0]        mode
);

  tket_pkg::rx_mode_t rx_mode;
  tket_pkg::rx_mode_t rx_mode_next;
  logic [31:0] last_edge;
  logic [31:0] last_edge_next;
  logic [31:0] last_flush;
  logic [31:0] last_flush_next;
  logic [7:0]  confirm_count;
  logic [7:0]  confirm_count_next;
  logic [2:0]  ev;
  logic [31:0] dur;
  logic        active;
  logic        want_change;
  logic [7:0]  count_inc;
  logic [31:0] total;
  logic [31:0] since;

  assign q_pop = q_nonempty && (!out_valid || out_ready);

  // Debounce, edge timing and silence timeouts for one word
  always_comb begin
    rx_mode_next       = rx_mode;
    last_edge_next     = last_edge;
    last_flush_next    = last_flush;
    confirm_count_next = confirm_count;
    ev                 = tket_pkg::EV_NONE;
    dur                = '0;
    active             = q_item.average >= cfg.level_threshold;
    count_inc          = confirm_count + 1'b1;
    want_change        = active;
    unique case (rx_mode)
      tket_pkg::RX_TONE: want_change = !active;
      default:           want_change = active;
    endcase
    total = '0;
    since = '0;
    if (!q_item.decoder_done) begin
      if (want_change) begin
        confirm_count_next = count_inc;
        if (count_inc >= cfg.debounce_samples) begin
          dur = q_item.time_ms - last_edge;
          if (rx_mode == tket_pkg::RX_TONE) begin
            ev           = tket_pkg::EV_TONE_END;
            rx_mode_next = tket_pkg::RX_SILENT;
          end else begin
            ev           = tket_pkg::EV_SILENCE_END;
            rx_mode_next = tket_pkg::RX_TONE;
          end
          last_edge_next     = q_item.time_ms;
          last_flush_next    = q_item.time_ms;
          confirm_count_next = '0;
        end
      end else begin
        confirm_count_next = '0;
      end
      total = q_item.time_ms - last_edge_next;
      since = q_item.time_ms - last_flush_next;
      if (rx_mode_next == tket_pkg::RX_SILENT) begin
        if (total >= {8'd0, cfg.message_end_ms}) begin
          if (q_item.decoder_has_text && ev == tket_pkg::EV_NONE) ev = tket_pkg::EV_MSG_END;
        end else if (since >= {16'd0, cfg.letter_flush_ms}) begin
          last_flush_next = q_item.time_ms;
          if (ev == tket_pkg::EV_NONE) ev = tket_pkg::EV_FLUSH;
        end
      end
    end
  end

  // Advance receiver state on each popped word
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode       <= tket_pkg::RX_IDLE;
      last_edge     <= '0;
      last_flush    <= '0;
      confirm_count <= '0;
    end else if (q_pop) begin
      rx_mode       <= rx_mode_next;
      last_edge     <= last_edge_next;
      last_flush    <= last_flush_next;
      confirm_count <= confirm_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      event_res   <= ev;
      duration_ms <= dur;
      average     <= q_item.average;
      mode        <= tket_pkg::mode_code(rx_mode_next);
    end
  end

endmodule

FILE: rtl/tone_keying_edge_timer_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Contents
// s_        in   s_tvalid/s_tready  tdata: sample, time_ms; tuser: decoder_done, decoder_has_text
// m_        out  m_tvalid/m_tready  tdata: duration_ms, average, mode; tuser: event_res
// cfg_      in   cfg_we             cfg_index selects register, cfg_data is the value
//
// One word per cycle sustained while the output keeps up; a word passes through the
// averaging stage, the four-entry queue and the output register, in that order.
// The average is a running window sum scaled by one reciprocal multiply.
// Synchronous reset; no clearing pass, the window fills from the first sample.
// A stalled output fills the queue; input stalls only once it is full.

module tone_keying_edge_timer_unit #(
  parameter int WINDOW_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [11:0] sample, [43:12] time_ms, [47:44] zero
  input  logic [1:0]  s_tuser,   // [0] decoder_done, [1] decoder_has_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] duration_ms, [43:32] average, [45:44] mode
  output logic [2:0]  m_tuser,   // [2:0] event_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  tket_pkg::cfg_t    cfg;
  tket_pkg::q_item_t push_item;
  tket_pkg::q_item_t pop_item;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_nonempty;
  logic [31:0]       duration_ms;
  logic [11:0]       average;
  logic [1:0]        mode;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold  <= 12'd2048;
      cfg.debounce_samples <= 8'd3;
      cfg.letter_flush_ms  <= 16'd1000;
      cfg.message_end_ms   <= 24'd3000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tket_pkg::REG_LEVEL_THRESHOLD:  cfg.level_threshold  <= cfg_data[11:0];
        tket_pkg::REG_DEBOUNCE_SAMPLES: cfg.debounce_samples <= cfg_data[7:0];
        tket_pkg::REG_LETTER_FLUSH_MS:  cfg.letter_flush_ms  <= cfg_data[15:0];
        tket_pkg::REG_MESSAGE_END_MS:   cfg.message_end_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  tket_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .sample           (s_tdata[11:0]),
    .time_ms          (s_tdata[43:12]),
    .decoder_done     (s_tuser[0]),
    .decoder_has_text (s_tuser[1]),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  tket_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (pop_item)
  );

  tket_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_nonempty  (q_nonempty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .event_res   (m_tuser),
    .duration_ms (duration_ms),
    .average     (average),
    .mode        (mode)
  );

  // Pack result word
  assign m_tdata = {2'b00, mode, average, duration_ms};

endmodule

FILE: sim/tone_keying_edge_timer_unit_tb.sv
`timescale 1ns / 1ps

module tone_keying_edge_timer_unit_tb;

  localparam int WIN_LEN = 8;

  // One result word as the block reports it
  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] dur;
    logic [11:0] avg;
    logic [1:0]  mode;
  } keying_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // [11:0] sample, [43:12] time_ms, [47:44] zero
  logic [1:0]  s_tuser;   // [0] decoder_done, [1] decoder_has_text
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [31:0] duration_ms, [43:32] average, [45:44] mode
  logic [2:0]  m_tuser;   // [2:0] event_res
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  // Predictor state: averaging window and keying timers
  logic [11:0] win_mem [WIN_LEN];
  int          win_ptr;
  bit          win_full;
  logic [1:0]  rx_state;
  logic [31:0] last_edge_ms;
  logic [31:0] flush_mark;
  logic [7:0]  confirm_cnt;

  // Shadow copy of the register set
  logic [11:0] thr_reg;
  logic [7:0]  deb_reg;
  logic [15:0] flush_reg;
  logic [23:0] msg_reg;

  keying_word_t pending_results[$];
  logic [31:0]  clock_ms;
  int           errors;
  bit           steady_src;
  bit           steady_snk;

  tone_keying_edge_timer_unit #(.WINDOW_LEN(WIN_LEN)) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the predictor by one sample and return the word it must produce
  function automatic keying_word_t predict_keying(input logic [11:0] smp,
                                                  input logic [31:0] now,
                                                  input bit done, input bit has_text);
    keying_word_t r;
    int          sum;
    bit          active;
    bit          flip;
    logic [31:0] total;
    logic [31:0] since;
    r.ev  = tket_pkg::EV_NONE;
    r.dur = '0;
    if (!done) begin
      win_mem[win_ptr] = smp;
      win_ptr = (win_ptr + 1) % WIN_LEN;
      if (!win_full) begin
        for (int i = 0; i < WIN_LEN; i++) win_mem[i] = smp;
        win_full = 1'b1;
      end
    end
    sum = 0;
    for (int i = 0; i < WIN_LEN; i++) sum += win_mem[i];
    r.avg = 12'(sum / WIN_LEN);
    if (!done) begin
      active = (r.avg >= thr_reg);
      flip = (rx_state == tket_pkg::MODE_CODE_TONE) ? !active : active;
      // Count opposite-level samples; confirm the edge once debounce is met
      if (flip) begin
        confirm_cnt = confirm_cnt + 8'd1;
        if (confirm_cnt >= deb_reg) begin
          r.dur = now - last_edge_ms;
          if (rx_state == tket_pkg::MODE_CODE_TONE) begin
            r.ev = tket_pkg::EV_TONE_END;
            rx_state = tket_pkg::MODE_CODE_SILENT;
          end else begin
            r.ev = tket_pkg::EV_SILENCE_END;
            rx_state = tket_pkg::MODE_CODE_TONE;
          end
          last_edge_ms = now;
          flush_mark   = now;
          confirm_cnt  = '0;
        end
      end else begin
        confirm_cnt = '0;
      end
      // Silence timeouts: message end wins over letter flush
      if (rx_state == tket_pkg::MODE_CODE_SILENT) begin
        total = now - last_edge_ms;
        since = now - flush_mark;
        if (total >= {8'd0, msg_reg}) begin
          if (has_text && r.ev == tket_pkg::EV_NONE) r.ev = tket_pkg::EV_MSG_END;
        end else if (since >= {16'd0, flush_reg}) begin
          flush_mark = now;
          if (r.ev == tket_pkg::EV_NONE) r.ev = tket_pkg::EV_FLUSH;
        end
      end
    end
    r.mode = rx_state;
    return r;
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_sample(input logic [11:0] smp, input logic [31:0] t_ms,
                             input bit done, input bit has_text);
    int gap;
    gap = steady_src ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, t_ms, smp};
    s_tuser  <= {has_text, done};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_keying(smp, t_ms, done, has_text));
  endtask

  // Stop sending and let every expected word come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register once the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tket_pkg::REG_LEVEL_THRESHOLD:  thr_reg   = val[11:0];
      tket_pkg::REG_DEBOUNCE_SAMPLES: deb_reg   = val[7:0];
      tket_pkg::REG_LETTER_FLUSH_MS:  flush_reg = val[15:0];
      tket_pkg::REG_MESSAGE_END_MS:   msg_reg   = val[23:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [11:0] thr, input logic [7:0] deb,
                            input logic [15:0] flush, input logic [23:0] msg);
    write_reg(tket_pkg::REG_LEVEL_THRESHOLD, {12'b0, thr});
    write_reg(tket_pkg::REG_DEBOUNCE_SAMPLES, {16'b0, deb});
    write_reg(tket_pkg::REG_LETTER_FLUSH_MS, {8'b0, flush});
    write_reg(tket_pkg::REG_MESSAGE_END_MS, msg);
  endtask

  // First sample fills the window; leave idle with a timestamp that wraps
  task automatic test_startup();
    send_sample(12'hFFF, 32'h0000_0000, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(12'hFFF, 32'h0000_0010, 1'b0, 1'b1);
    clock_ms = 32'h0000_0010;
  endtask

  // Done input freezes everything, whatever the sample
  task automatic test_frozen();
    send_sample(12'h000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_sample(12'hABC, 32'h1234_5678, 1'b1, 1'b0);
  endtask

  // Falling average ends the tone; duration spans the time wrap
  task automatic test_tone_end();
    for (int i = 0; i < 7; i++) begin
      clock_ms += 32'h2AAA_AAAA;
      send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    end
  endtask

  // Gated message end, repeated message end, frozen step
  task automatic test_timeouts();
    clock_ms += 1000;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 999;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 1001;
    send_sample(12'h000, clock_ms, 1'b0, 1'b0);
    clock_ms += 1;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 1;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 1;
    send_sample(12'h000, clock_ms, 1'b1, 1'b1);
    clock_ms += 1;
    send_sample(12'hFFF, clock_ms, 1'b0, 1'b0);
  endtask

  // Zero debounce and zero timeouts: edge and timeout on the same step
  task automatic test_zero_registers();
    set_config(12'd0, 8'd0, 16'd0, 24'd0);
    clock_ms += 5;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 2;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    write_reg(tket_pkg::REG_LEVEL_THRESHOLD, 24'hFFF);
    clock_ms += 3;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    clock_ms += 4;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    write_reg(tket_pkg::REG_MESSAGE_END_MS, 24'hFF_FFFF);
    clock_ms += 5;
    send_sample(12'h000, clock_ms, 1'b0, 1'b1);
    write_reg(tket_pkg::REG_LEVEL_THRESHOLD, 24'h0);
    clock_ms += 1;
    send_sample(12'h000, clock_ms, 1'b0, 1'b0);
    write_reg(tket_pkg::REG_LEVEL_THRESHOLD, 24'hFFF);
    clock_ms += 1;
    send_sample(12'h000, clock_ms, 1'b0, 1'b0);
  endtask

  // Alternating tone and silence runs with glitches, noise bursts and time jumps
  task automatic run_keying_traffic(input int n_items);
    int          sent;
    int          seg_len;
    int          pick;
    bit          level_hi;
    bit          noisy;
    logic [11:0] smp;
    sent = 0;
    level_hi = ($urandom_range(0, 1) == 1);
    while (sent < n_items) begin
      steady_src = ($urandom_range(0, 4) == 0);
      noisy = ($urandom_range(0, 6) == 0);
      seg_len = noisy ? $urandom_range(1, 4)
                      : $urandom_range(1, 32'(deb_reg) + 32'(deb_reg) / 2 + 8);
      for (int i = 0; i < seg_len && sent < n_items; i++) begin
        if (noisy)
          smp = 12'($urandom);
        else if (level_hi ^ ($urandom_range(0, 19) == 0))
          smp = 12'($urandom_range(32'(thr_reg), 4095));
        else
          smp = (thr_reg == 0) ? 12'd0 : 12'($urandom_range(0, 32'(thr_reg) - 1));
        pick = $urandom_range(0, 99);
        if (pick < 2)
          clock_ms = $urandom;
        else if (pick < 7)
          clock_ms += $urandom_range(0, 32'(msg_reg) + 32'(msg_reg) / 2 + 1);
        else
          clock_ms += $urandom_range(0, 32'(flush_reg) / 2 + 1);
        send_sample(smp, clock_ms, $urandom_range(0, 24) == 0, $urandom_range(0, 9) < 7);
        sent++;
        // hold off once mid-phase until the block has emptied
        if (sent == n_items / 2) wait_drained();
      end
      level_hi = !level_hi;
    end
    steady_src = 1'b0;
  endtask

  task automatic test_random_traffic();
    set_config(12'd2048, 8'd3, 16'd1000, 24'd3000);
    run_keying_traffic(110);
    set_config(12'($urandom_range(256, 3840)), 8'($urandom_range(1, 8)),
               16'($urandom_range(20, 600)), 24'($urandom_range(100, 5000)));
    run_keying_traffic(110);
    set_config(12'hFFF, 8'hFF, 16'hFFFF, 24'hFF_FFFF);
    run_keying_traffic(110);
    set_config(12'd1, 8'd1, 16'd1, 24'd1);
    run_keying_traffic(110);
    set_config(12'($urandom_range(0, 4095)), 8'($urandom_range(1, 16)),
               16'($urandom_range(1, 65535)), 24'($urandom_range(1, 24'hFF_FFFF)));
    run_keying_traffic(110);
  endtask

  // Result side: random stalls, with stretches of none
  initial begin : sink_stalls
    int n;
    m_tready   = 1'b0;
    steady_snk = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) steady_snk = !steady_snk;
      n = steady_snk ? 0 : $urandom_range(0, 9);
      repeat (n) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && !rst));
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Compare each word taken from the block with the oldest expectation
  always @(posedge clk) begin : check_results
    keying_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, expected none, actual tdata %0h tuser %0h",
                 $time, m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 32'(want.ev), 32'(m_tuser));
        check_field("duration_ms", want.dur, m_tdata[31:0]);
        check_field("average", 32'(want.avg), 32'(m_tdata[43:32]));
        check_field("mode", 32'(want.mode), 32'(m_tdata[45:44]));
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = tket_pkg::REG_LEVEL_THRESHOLD;
    cfg_data  = '0;
    errors    = 0;
    clock_ms  = '0;
    steady_src = 1'b0;
    // predictor reset state
    for (int i = 0; i < WIN_LEN; i++) win_mem[i] = '0;
    win_ptr      = 0;
    win_full     = 1'b0;
    rx_state     = tket_pkg::MODE_CODE_IDLE;
    last_edge_ms = '0;
    flush_mark   = '0;
    confirm_cnt  = '0;
    thr_reg      = 12'd2048;
    deb_reg      = 8'd3;
    flush_reg    = 16'd1000;
    msg_reg      = 24'd3000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_startup();
    test_frozen();
    test_tone_end();
    test_timeouts();
    test_zero_registers();
    test_random_traffic();
    wait_drained();

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: tone_keying_edge_timer_unit.f
+incdir+rtl
rtl/tket_pkg.sv
rtl/tket_front.sv
rtl/tket_queue.sv
rtl/tket_back.sv
rtl/tone_keying_edge_timer_unit.sv
sim/tone_keying_edge_timer_unit_tb.sv
